### rtl/core/ezr_pkg.sv
// Shared constants and types for the Euler ZYX rotation matrix core.
package ezr_pkg;

    localparam int ANGLE_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF = 14;
    localparam int WORK_BITS = 30;
    localparam int CORDIC_STEPS = 30;
    localparam int STEP_BITS = 5;
    localparam int DATA_BITS = 33;
    localparam int ZW = 32;
    localparam logic signed [DATA_BITS-1:0] CORDIC_START = 33'sd652032874;

    typedef logic signed [DATA_BITS-1:0] data_t;
    typedef logic signed [ZW-1:0] zacc_t;

    typedef struct packed {
        data_t       x;
        data_t       y;
        zacc_t       z;
        logic [1:0]  quad;
    } cordic_t;

    typedef struct packed {
        cordic_t ax;
        cordic_t ay;
        cordic_t az;
    } trio_t;

    function automatic zacc_t atan_turn(input logic [STEP_BITS-1:0] idx);
        zacc_t r;
        case (idx)
            5'd0: r = 32'sd536870912;
            5'd1: r = 32'sd316933406;
            5'd2: r = 32'sd167458907;
            5'd3: r = 32'sd85004756;
            5'd4: r = 32'sd42667331;
            5'd5: r = 32'sd21354465;
            5'd6: r = 32'sd10679838;
            5'd7: r = 32'sd5340245;
            5'd8: r = 32'sd2670163;
            5'd9: r = 32'sd1335087;
            5'd10: r = 32'sd667544;
            5'd11: r = 32'sd333772;
            5'd12: r = 32'sd166886;
            5'd13: r = 32'sd83443;
            5'd14: r = 32'sd41722;
            5'd15: r = 32'sd20861;
            5'd16: r = 32'sd10430;
            5'd17: r = 32'sd5215;
            5'd18: r = 32'sd2608;
            5'd19: r = 32'sd1304;
            5'd20: r = 32'sd652;
            5'd21: r = 32'sd326;
            5'd22: r = 32'sd163;
            5'd23: r = 32'sd81;
            5'd24: r = 32'sd41;
            5'd25: r = 32'sd20;
            5'd26: r = 32'sd10;
            5'd27: r = 32'sd5;
            5'd28: r = 32'sd3;
            5'd29: r = 32'sd1;
            default: r = 32'sd0;
        endcase
        return r;
    endfunction

    function automatic cordic_t cordic_step(input cordic_t c, input logic [STEP_BITS-1:0] idx);
        cordic_t o;
        data_t xs;
        data_t ys;
        zacc_t t;
        xs = c.x >>> idx;
        ys = c.y >>> idx;
        t = atan_turn(idx);
        o = c;
        if (!c.z[ZW-1])
        begin
            o.x = c.x - ys;
            o.y = c.y + xs;
            o.z = c.z - t;
        end
        else
        begin
            o.x = c.x + ys;
            o.y = c.y - xs;
            o.z = c.z + t;
        end
        return o;
    endfunction

endpackage

### rtl/core/ezr_cell.sv
// One CORDIC micro-rotation cell handling three angles with a valid bit.
module ezr_cell #(
    parameter logic [ezr_pkg::STEP_BITS-1:0] STEP = '0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            advance,
    input  logic            valid_in,
    input  ezr_pkg::trio_t  data_in,
    output logic            valid_out,
    output ezr_pkg::trio_t  data_out
);

    logic           valid_reg;
    ezr_pkg::trio_t data_reg;
    ezr_pkg::trio_t data_next;

    always_comb
    begin
        data_next.ax = ezr_pkg::cordic_step(data_in.ax, STEP);
        data_next.ay = ezr_pkg::cordic_step(data_in.ay, STEP);
        data_next.az = ezr_pkg::cordic_step(data_in.az, STEP);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            data_reg <= data_next;
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

### rtl/core/ezr_matrix.sv
// Quadrant fixup, product stages and output rounding for the nine entries.
module ezr_matrix #(
    parameter int FRAC_BITS = ezr_pkg::FRAC_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        advance,
    input  logic                        valid_in,
    input  ezr_pkg::trio_t              data_in,
    output logic                        valid_out,
    output logic signed [FRAC_BITS+1:0] ent [9]
);

    localparam int WB = ezr_pkg::WORK_BITS;
    localparam int DB = ezr_pkg::DATA_BITS;
    localparam int SH = WB - FRAC_BITS;
    localparam int OW = FRAC_BITS + 2;

    typedef logic signed [DB-1:0] d_t;
    typedef logic signed [2*DB-1:0] p_t;

    function automatic d_t qmul(input d_t a, input d_t b);
        p_t p;
        p = p_t'(a) * p_t'(b) + (p_t'(1) <<< (WB - 1));
        return d_t'(p >>> WB);
    endfunction

    function automatic logic signed [OW-1:0] to_out(input d_t v);
        d_t r;
        d_t one;
        one = d_t'(1) <<< FRAC_BITS;
        if (SH > 0)
            r = (v + (d_t'(1) <<< (SH > 0 ? SH - 1 : 0))) >>> SH;
        else
            r = v;
        if (r > one)
            r = one;
        if (r < -one)
            r = -one;
        return r[OW-1:0];
    endfunction

    function automatic void fix(input ezr_pkg::cordic_t c, output d_t co, output d_t so);
        case (c.quad)
            2'd0: begin co = c.x;  so = c.y;  end
            2'd1: begin co = -c.y; so = c.x;  end
            2'd2: begin co = -c.x; so = -c.y; end
            default: begin co = c.y; so = -c.x; end
        endcase
    endfunction

    d_t ci_next, si_next, cj_next, sj_next, ch_next, sh_next;
    d_t ci_reg, si_reg, cj_reg, sj_reg, ch_reg, sh_reg;
    d_t cc_reg, cs_reg, sc_reg, ss_reg, cj2_reg, sj2_reg, ch2_reg, sh2_reg;
    d_t ci2_reg, si2_reg;
    d_t e_reg [9];
    logic [2:0] v_reg;

    always_comb
    begin
        fix(data_in.ax, ci_next, si_next);
        fix(data_in.ay, cj_next, sj_next);
        fix(data_in.az, ch_next, sh_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (advance)
            v_reg <= {v_reg[1:0], valid_in};
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ci_reg <= ci_next;
            si_reg <= si_next;
            cj_reg <= cj_next;
            sj_reg <= sj_next;
            ch_reg <= ch_next;
            sh_reg <= sh_next;
            cc_reg <= qmul(ci_reg, ch_reg);
            cs_reg <= qmul(ci_reg, sh_reg);
            sc_reg <= qmul(si_reg, ch_reg);
            ss_reg <= qmul(si_reg, sh_reg);
            cj2_reg <= cj_reg;
            sj2_reg <= sj_reg;
            ch2_reg <= ch_reg;
            sh2_reg <= sh_reg;
            ci2_reg <= ci_reg;
            si2_reg <= si_reg;
            e_reg[0] <= qmul(cj2_reg, ch2_reg);
            e_reg[1] <= qmul(sj2_reg, sc_reg) - cs_reg;
            e_reg[2] <= qmul(sj2_reg, cc_reg) + ss_reg;
            e_reg[3] <= qmul(cj2_reg, sh2_reg);
            e_reg[4] <= qmul(sj2_reg, ss_reg) + cc_reg;
            e_reg[5] <= qmul(sj2_reg, cs_reg) - sc_reg;
            e_reg[6] <= -sj2_reg;
            e_reg[7] <= qmul(cj2_reg, si2_reg);
            e_reg[8] <= qmul(cj2_reg, ci2_reg);
        end
    end

    always_comb
    begin
        for (int k = 0; k < 9; k++)
            ent[k] = to_out(e_reg[k]);
    end

    assign valid_out = v_reg[2];

endmodule

### rtl/core/euler_zyx_rotation_matrix_core.sv
// Top level of the Euler ZYX rotation matrix core.
// Accepts one angle triple per cycle while not stalled and returns the nine Q1.FRAC_BITS
// entries of the ZYX rotation matrix from its 33rd register stage: 30 stages in the row of
// CORDIC cells (one micro-rotation per cell for all three angles), then 1 stage after
// quadrant fixup and 2 product stages, with output rounding combinational on the last
// stage. The whole pipeline, bubbles included, stalls when the output is stalled while a
// result is held.
module euler_zyx_rotation_matrix_core #(
    parameter int ANGLE_BITS = ezr_pkg::ANGLE_BITS_DEF,
    parameter int FRAC_BITS  = ezr_pkg::FRAC_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [ANGLE_BITS-1:0]       angle_x,
    input  logic [ANGLE_BITS-1:0]       angle_y,
    input  logic [ANGLE_BITS-1:0]       angle_z,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [FRAC_BITS+1:0] col0_row0,
    output logic signed [FRAC_BITS+1:0] col0_row1,
    output logic signed [FRAC_BITS+1:0] col0_row2,
    output logic signed [FRAC_BITS+1:0] col1_row0,
    output logic signed [FRAC_BITS+1:0] col1_row1,
    output logic signed [FRAC_BITS+1:0] col1_row2,
    output logic signed [FRAC_BITS+1:0] col2_row0,
    output logic signed [FRAC_BITS+1:0] col2_row1,
    output logic signed [FRAC_BITS+1:0] col2_row2
);

    localparam int N = ezr_pkg::CORDIC_STEPS;

    logic           advance;
    logic           v [N+1];
    ezr_pkg::trio_t d [N+1];
    logic signed [FRAC_BITS+1:0] ent [9];

    function automatic ezr_pkg::cordic_t seed(input logic [ANGLE_BITS-1:0] a);
        ezr_pkg::cordic_t c;
        logic [31:0] t;
        t = {a, {(32 - ANGLE_BITS){1'b0}}};
        c.x = ezr_pkg::CORDIC_START;
        c.y = '0;
        c.z = ezr_pkg::zacc_t'({2'b00, t[29:0]});
        c.quad = t[31:30];
        return c;
    endfunction

    assign advance  = !(out_valid && out_stall);
    assign in_stall = !advance;

    assign v[0] = in_valid;
    assign d[0] = '{ax: seed(angle_x), ay: seed(angle_y), az: seed(angle_z)};

    for (genvar g = 0; g < N; g++)
    begin : g_cell
        ezr_cell #(
            .STEP(ezr_pkg::STEP_BITS'(g))
        ) u_cell (
            .clk(clk),
            .rst_n(rst_n),
            .advance(advance),
            .valid_in(v[g]),
            .data_in(d[g]),
            .valid_out(v[g+1]),
            .data_out(d[g+1])
        );
    end

    ezr_matrix #(
        .FRAC_BITS(FRAC_BITS)
    ) u_matrix (
        .clk(clk),
        .rst_n(rst_n),
        .advance(advance),
        .valid_in(v[N]),
        .data_in(d[N]),
        .valid_out(out_valid),
        .ent(ent)
    );

    assign col0_row0 = ent[0];
    assign col0_row1 = ent[1];
    assign col0_row2 = ent[2];
    assign col1_row0 = ent[3];
    assign col1_row1 = ent[4];
    assign col1_row2 = ent[5];
    assign col2_row0 = ent[6];
    assign col2_row1 = ent[7];
    assign col2_row2 = ent[8];

`ifndef SYNTHESIS
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(col0_row0) && $stable(col2_row2))
        else $error("held result changed");
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("input stall mismatch");
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> col2_row0 <= (1 <<< FRAC_BITS) && col2_row0 >= -(1 <<< FRAC_BITS))
        else $error("entry out of range");
`endif

endmodule

### sim/euler_zyx_rotation_matrix_core_test.sv
// Testbench for the Euler ZYX rotation matrix core: directed table plus random angles.
module euler_zyx_rotation_matrix_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ABITS = 16;
    localparam int FBITS = 14;
    localparam int OW = FBITS + 2;
    localparam int RANDOM_ITEMS = 650;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 60;
    localparam longint ONE_Q = 64'sd1 << FBITS;

    typedef logic signed [OW-1:0] entry_t;
    typedef struct {
        entry_t m [9];
    } matrix_t;
    typedef struct {
        logic [ABITS-1:0] ax;
        logic [ABITS-1:0] ay;
        logic [ABITS-1:0] az;
        bit               known;
        matrix_t          mat;
    } angle_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [ABITS-1:0] angle_x = '0;
    logic [ABITS-1:0] angle_y = '0;
    logic [ABITS-1:0] angle_z = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    entry_t col0_row0, col0_row1, col0_row2, col1_row0, col1_row1, col1_row2;
    entry_t col2_row0, col2_row1, col2_row2;

    euler_zyx_rotation_matrix_core #(.ANGLE_BITS(ABITS), .FRAC_BITS(FBITS)) DUT (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    matrix_t pending_matrices [$];
    angle_row_t directed_rows [$];
    int mismatches = 0;
    int idle_cycles = 0;
    bit sending_done = 0;
    bit long_hold = 0;
    bit rx_quiet = 0;

    const longint atan_turn32 [30] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1};

    function automatic void cordic_sincos(input logic [ABITS-1:0] a, output longint c,
                                          output longint s);
        logic [31:0] turn;
        longint x, y, z, nx;
        turn = {a, {(32 - ABITS){1'b0}}};
        z = longint'(turn[29:0]);
        x = 652032874;
        y = 0;
        for (int i = 0; i < 30; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z = z - atan_turn32[i];
            end
            else
            begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z = z + atan_turn32[i];
            end
            x = nx;
        end
        case (turn[31:30])
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endfunction

    function automatic longint q30_mul(longint a, longint b);
        return (a * b + (64'sd1 << 29)) >>> 30;
    endfunction

    function automatic entry_t round_sat(longint v);
        longint r;
        r = (v + (64'sd1 << (29 - FBITS))) >>> (30 - FBITS);
        if (r > ONE_Q)
            r = ONE_Q;
        if (r < -ONE_Q)
            r = -ONE_Q;
        return entry_t'(r);
    endfunction

    function automatic matrix_t rotation_matrix(logic [ABITS-1:0] ax, logic [ABITS-1:0] ay,
                                                logic [ABITS-1:0] az);
        longint ci, si, cj, sj, ch, sh, cc, cs, sc, ss;
        matrix_t r;
        cordic_sincos(ax, ci, si);
        cordic_sincos(ay, cj, sj);
        cordic_sincos(az, ch, sh);
        cc = q30_mul(ci, ch);
        cs = q30_mul(ci, sh);
        sc = q30_mul(si, ch);
        ss = q30_mul(si, sh);
        r.m[0] = round_sat(q30_mul(cj, ch));
        r.m[1] = round_sat(q30_mul(sj, sc) - cs);
        r.m[2] = round_sat(q30_mul(sj, cc) + ss);
        r.m[3] = round_sat(q30_mul(cj, sh));
        r.m[4] = round_sat(q30_mul(sj, ss) + cc);
        r.m[5] = round_sat(q30_mul(sj, cs) - sc);
        r.m[6] = round_sat(-sj);
        r.m[7] = round_sat(q30_mul(cj, si));
        r.m[8] = round_sat(q30_mul(cj, ci));
        return r;
    endfunction

    function automatic angle_row_t row(int ax, int ay, int az, bit known = 0,
                                       int e0 = 0, int e1 = 0, int e2 = 0,
                                       int e3 = 0, int e4 = 0, int e5 = 0,
                                       int e6 = 0, int e7 = 0, int e8 = 0);
        angle_row_t r;
        r.ax = ABITS'(ax);
        r.ay = ABITS'(ay);
        r.az = ABITS'(az);
        r.known = known;
        r.mat.m = '{entry_t'(e0), entry_t'(e1), entry_t'(e2), entry_t'(e3),
                    entry_t'(e4), entry_t'(e5), entry_t'(e6), entry_t'(e7),
                    entry_t'(e8)};
        return r;
    endfunction

    function automatic void add_row(angle_row_t r);
        directed_rows = {directed_rows, r};
    endfunction

    task automatic send_angles(logic [ABITS-1:0] ax, logic [ABITS-1:0] ay,
                               logic [ABITS-1:0] az, matrix_t m);
        int gap;
        gap = $urandom_range(0, 6);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        repeat (gap)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        angle_x <= ax;
        angle_y <= ay;
        angle_z <= az;
        do
            @(posedge clk);
        while (in_stall);
        pending_matrices = {pending_matrices, m};
    endtask

    function automatic logic [ABITS-1:0] rand_angle();
        case ($urandom_range(0, 4))
            0: return ABITS'($urandom_range(0, 3) << (ABITS - 2));
            1: return ABITS'(($urandom_range(0, 3) << (ABITS - 2)) + $urandom_range(0, 3)
                             - 2);
            default: return ABITS'($urandom());
        endcase
    endfunction

    initial
    begin
        angle_row_t r;
        logic [ABITS-1:0] ax, ay, az;
        // quarter turns give exact entries; CORDIC gain error stays below one output lsb
        add_row(row(0, 0, 0, 1, 16384, 0, 0, 0, 16384, 0, 0, 0, 16384));
        add_row(row(16384, 0, 0, 1, 16384, 0, 0, 0, 0, -16384, 0, 16384, 0));
        add_row(row(0, 16384, 0, 1, 0, 0, 16384, 0, 16384, 0, -16384, 0, 0));
        add_row(row(0, 0, 16384, 1, 0, -16384, 0, 16384, 0, 0, 0, 0, 16384));
        add_row(row(32768, 32768, 32768, 1, 16384, 0, 0, 0, 16384, 0, 0, 0, 16384));
        add_row(row(65535, 65535, 65535));
        add_row(row(49152, 49152, 49152));
        add_row(row(1, 1, 1));
        add_row(row(16383, 16385, 32767));
        add_row(row(32769, 49151, 49153));
        add_row(row(8192, 8192, 8192));
        add_row(row(24576, 40960, 57344));
        add_row(row(43690, 21845, 65535));
        add_row(row(21845, 43690, 0));
        add_row(row(12345, 54321, 33333));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            r = directed_rows[i];
            send_angles(r.ax, r.ay, r.az,
                        r.known ? r.mat : rotation_matrix(r.ax, r.ay, r.az));
        end
        in_valid <= 1'b0;
        wait (pending_matrices.size() == 0);
        @(posedge clk);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == 200)
                long_hold = 1;
            if (n == 400)
            begin
                in_valid <= 1'b0;
                wait (pending_matrices.size() == 0);
                @(posedge clk);
            end
            ax = rand_angle();
            ay = rand_angle();
            az = rand_angle();
            send_angles(ax, ay, az, rotation_matrix(ax, ay, az));
        end
        in_valid <= 1'b0;
        sending_done = 1;
    end

    initial
    begin
        int gap;
        forever
        begin
            if (long_hold)
            begin
                long_hold = 0;
                out_stall <= 1'b1;
                repeat (120) @(posedge clk);
            end
            if (rx_quiet)
                gap = 0;
            else
                gap = $urandom_range(0, 6);
            if ($urandom_range(0, 3) == 0)
                gap = 0;
            repeat (gap)
            begin
                out_stall <= 1'b1;
                @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
            if ($urandom_range(0, 40) == 0)
                rx_quiet = !rx_quiet;
        end
    end

    always @(posedge clk)
    begin
        matrix_t want;
        entry_t got [9];
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{col0_row0, col0_row1, col0_row2, col1_row0, col1_row1, col1_row2,
                    col2_row0, col2_row1, col2_row2};
            if (pending_matrices.size() == 0)
            begin
                $error("unexpected result transaction");
                mismatches++;
            end
            else
            begin
                want = pending_matrices.pop_front();
                for (int k = 0; k < 9; k++)
                    if (got[k] !== want.m[k])
                    begin
                        $error("col%0d_row%0d: expected %0d, got %0d", k / 3, k % 3,
                               want.m[k], got[k]);
                        mismatches++;
                    end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        wait (sending_done && pending_matrices.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("Mismatches found");
        $finish;
    end
endmodule
